[rtl/dru_pkg.sv]
package dru_pkg;

    localparam logic [2:0] KIND_DIV_MODE  = 3'd0;
    localparam logic [2:0] KIND_NUMER_LO  = 3'd1;
    localparam logic [2:0] KIND_NUMER_HI  = 3'd2;
    localparam logic [2:0] KIND_DENOM_LO  = 3'd3;
    localparam logic [2:0] KIND_DENOM_HI  = 3'd4;
    localparam logic [2:0] KIND_ROOT_MODE = 3'd5;
    localparam logic [2:0] KIND_ROOT_LO   = 3'd6;
    localparam logic [2:0] KIND_ROOT_HI   = 3'd7;

    localparam logic [1:0] DIV_MODE_32_32 = 2'd0;
    localparam logic [1:0] DIV_MODE_64_64 = 2'd2;

    localparam int STEPS = 64;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] write_mask;
        logic [31:0] write_value;
    } dru_in_t;

    typedef struct packed {
        logic signed [63:0] quotient;
        logic signed [63:0] remainder;
        logic               divide_by_zero;
        logic [1:0]         divide_mode;
        logic [31:0]        root;
        logic               root_mode;
    } dru_out_t;

    typedef struct packed {
        logic load;
        logic step;
        logic finish;
    } dru_cmd_t;

    typedef struct packed {
        logic last;
    } dru_status_t;

endpackage

[rtl/dru_if.sv]
interface dru_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[rtl/divide_and_root_unit_top.sv]
// Divide and square-root unit.
// The in channel carries one register write per word: kind selects the
// register, and only the bits set in write_mask take write_value.
// After each write the unit recomputes a signed 64-bit divide and an
// unsigned floor square root from its registers and sends one word on
// the out channel with both results and the current modes.
// A result is built in order: the load at the accepting edge, the radix-2
// divide steps with the square-root steps beside them on one counter, and
// a last step to fix signs and special cases. One word is in work at a
// time: no new word is taken until the last has left the iteration.
// A result waits in its output register while the receiver stalls; the
// next write may be accepted then, and its result is held back until
// the waiting one is taken.
// Reset clears all operand and mode registers and results to zero and leaves out empty.
module divide_and_root_unit_top (
    input logic   clk,
    input logic   rst_n,
    dru_if.sink   in_ch,
    dru_if.source out_ch
);
    import dru_pkg::*;

    dru_cmd_t    cmd;
    dru_status_t status;

    dru_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .cmd       (cmd),
        .status    (status)
    );

    dru_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_word  (in_ch.data),
        .cmd      (cmd),
        .status   (status),
        .out_word (out_ch.data)
    );
endmodule

[rtl/dru_ctrl.sv]
module dru_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    output dru_pkg::dru_cmd_t    cmd,
    input  dru_pkg::dru_status_t status
);
    import dru_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                cmd.step = 1'b1;
                if (status.last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> state_reg == ST_IDLE)
        else $error("load outside idle");
    a_finish_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> out_valid_reg)
        else $error("finish without result");
    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.step, cmd.finish}))
        else $error("overlapping commands");
`endif
endmodule

[rtl/dru_datapath.sv]
module dru_datapath (
    input  logic                  clk,
    input  logic                  rst_n,
    input  dru_pkg::dru_in_t      in_word,
    input  dru_pkg::dru_cmd_t     cmd,
    output dru_pkg::dru_status_t  status,
    output dru_pkg::dru_out_t     out_word
);
    import dru_pkg::*;

    logic [1:0]  div_mode_reg;
    logic [63:0] numerator_reg;
    logic [63:0] denominator_reg;
    logic        root_mode_reg;
    logic [63:0] root_operand_reg;
    logic [63:0] quotient_reg;
    logic [63:0] remainder_reg;
    logic        zero_flag_reg;
    logic [31:0] root_reg;
    logic        out_zero_reg;
    logic [1:0]  out_div_mode_reg;
    logic        out_root_mode_reg;

    logic [1:0]  div_mode_next;
    logic [63:0] numerator_next;
    logic [63:0] denominator_next;
    logic        root_mode_next;
    logic [63:0] root_operand_next;
    logic [63:0] mask_lo;
    logic [63:0] mask_hi;
    logic [63:0] val_lo;
    logic [63:0] val_hi;

    // Iteration registers.
    logic [5:0]  count_reg;
    logic [63:0] ua_reg;
    logic [63:0] ub_reg;
    logic [63:0] uq_reg;
    logic [64:0] ur_reg;
    logic        neg_q_reg;
    logic        neg_r_reg;
    logic [1:0]  special_reg;
    logic [63:0] sq_x_reg;
    logic [65:0] sq_rem_reg;
    logic [31:0] sq_res_reg;

    logic [63:0] n_sel;
    logic [63:0] d_sel;
    logic [64:0] ur_shift;
    logic [64:0] ur_sub;
    logic [65:0] sq_shift;
    logic [65:0] sq_trial;
    logic [65:0] sq_sub;

    localparam logic [1:0] SP_NONE = 2'd0;
    localparam logic [1:0] SP_ZERO = 2'd1;
    localparam logic [1:0] SP_OVF  = 2'd2;

    assign mask_lo = {32'd0, in_word.write_mask};
    assign mask_hi = {in_word.write_mask, 32'd0};
    assign val_lo  = {32'd0, in_word.write_value & in_word.write_mask};
    assign val_hi  = {in_word.write_value & in_word.write_mask, 32'd0};

    always_comb
    begin
        div_mode_next     = div_mode_reg;
        numerator_next    = numerator_reg;
        denominator_next  = denominator_reg;
        root_mode_next    = root_mode_reg;
        root_operand_next = root_operand_reg;
        case (in_word.kind)
            KIND_DIV_MODE:
            begin
                div_mode_next = (div_mode_reg & ~in_word.write_mask[1:0])
                              | (in_word.write_value[1:0] & in_word.write_mask[1:0]);
            end
            KIND_NUMER_LO: numerator_next = (numerator_reg & ~mask_lo) | val_lo;
            KIND_NUMER_HI: numerator_next = (numerator_reg & ~mask_hi) | val_hi;
            KIND_DENOM_LO: denominator_next = (denominator_reg & ~mask_lo) | val_lo;
            KIND_DENOM_HI: denominator_next = (denominator_reg & ~mask_hi) | val_hi;
            KIND_ROOT_MODE:
            begin
                root_mode_next = (root_mode_reg & ~in_word.write_mask[0])
                               | (in_word.write_value[0] & in_word.write_mask[0]);
            end
            KIND_ROOT_LO: root_operand_next = (root_operand_reg & ~mask_lo) | val_lo;
            KIND_ROOT_HI: root_operand_next = (root_operand_reg & ~mask_hi) | val_hi;
            default: root_operand_next = root_operand_reg;
        endcase
    end

    always_comb
    begin
        if (div_mode_next == DIV_MODE_32_32)
        begin
            n_sel = {{32{numerator_next[31]}}, numerator_next[31:0]};
        end
        else
        begin
            n_sel = numerator_next;
        end
        if (div_mode_next == DIV_MODE_64_64)
        begin
            d_sel = denominator_next;
        end
        else
        begin
            d_sel = {{32{denominator_next[31]}}, denominator_next[31:0]};
        end
    end

    assign ur_shift = {ur_reg[63:0], ua_reg[63]};
    assign ur_sub   = ur_shift - {1'b0, ub_reg};
    assign sq_shift = {sq_rem_reg[63:0], sq_x_reg[63:62]};
    assign sq_trial = {32'd0, sq_res_reg, 2'b01};
    assign sq_sub   = sq_shift - sq_trial;

    assign status.last = (count_reg == 6'(STEPS - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_mode_reg      <= '0;
            numerator_reg     <= '0;
            denominator_reg   <= '0;
            root_mode_reg     <= 1'b0;
            root_operand_reg  <= '0;
            quotient_reg      <= '0;
            remainder_reg     <= '0;
            zero_flag_reg     <= 1'b0;
            root_reg          <= '0;
            out_zero_reg      <= 1'b0;
            out_div_mode_reg  <= '0;
            out_root_mode_reg <= 1'b0;
            count_reg         <= '0;
        end
        else if (cmd.load)
        begin
            div_mode_reg     <= div_mode_next;
            numerator_reg    <= numerator_next;
            denominator_reg  <= denominator_next;
            root_mode_reg    <= root_mode_next;
            root_operand_reg <= root_operand_next;
            zero_flag_reg    <= (denominator_next == 64'd0);
            count_reg        <= '0;
        end
        else if (cmd.step)
        begin
            count_reg <= count_reg + 6'd1;
        end
        else if (cmd.finish)
        begin
            root_reg          <= sq_res_reg;
            out_zero_reg      <= zero_flag_reg;
            out_div_mode_reg  <= div_mode_reg;
            out_root_mode_reg <= root_mode_reg;
            case (special_reg)
                SP_OVF:
                begin
                    quotient_reg  <= numerator_reg;
                    remainder_reg <= '0;
                end
                SP_ZERO:
                begin
                    if (div_mode_reg == DIV_MODE_32_32)
                    begin
                        quotient_reg  <= neg_r_reg ? 64'hFFFF_FFFF_0000_0001
                                                   : 64'h0000_0000_FFFF_FFFF;
                        remainder_reg <= {{32{numerator_reg[31]}}, numerator_reg[31:0]};
                    end
                    else
                    begin
                        quotient_reg  <= neg_r_reg ? 64'd1 : '1;
                        remainder_reg <= numerator_reg;
                    end
                end
                default:
                begin
                    quotient_reg  <= neg_q_reg ? -uq_reg : uq_reg;
                    remainder_reg <= neg_r_reg ? -ur_reg[63:0] : ur_reg[63:0];
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            ua_reg     <= n_sel[63] ? -n_sel : n_sel;
            ub_reg     <= d_sel[63] ? -d_sel : d_sel;
            neg_q_reg  <= n_sel[63] ^ d_sel[63];
            neg_r_reg  <= n_sel[63];
            uq_reg     <= '0;
            ur_reg     <= '0;
            sq_rem_reg <= '0;
            sq_res_reg <= '0;
            sq_x_reg   <= root_mode_next ? root_operand_next
                                         : {root_operand_next[31:0], 32'd0};
            if (div_mode_next != DIV_MODE_32_32 && n_sel == 64'h8000_0000_0000_0000
                && d_sel == '1)
            begin
                special_reg <= SP_OVF;
            end
            else if (d_sel == 64'd0)
            begin
                special_reg <= SP_ZERO;
            end
            else
            begin
                special_reg <= SP_NONE;
            end
        end
        else if (cmd.step)
        begin
            if (special_reg == SP_ZERO)
            begin
                ua_reg <= ua_reg;
            end
            else
            begin
                ua_reg <= {ua_reg[62:0], 1'b0};
                if (!ur_sub[64])
                begin
                    ur_reg <= ur_sub;
                    uq_reg <= {uq_reg[62:0], 1'b1};
                end
                else
                begin
                    ur_reg <= ur_shift;
                    uq_reg <= {uq_reg[62:0], 1'b0};
                end
            end
            if (count_reg < 6'd32 && (root_mode_reg || count_reg >= 6'd16))
            begin
                sq_x_reg <= {sq_x_reg[61:0], 2'b00};
                if (!sq_sub[65])
                begin
                    sq_rem_reg <= sq_sub;
                    sq_res_reg <= {sq_res_reg[30:0], 1'b1};
                end
                else
                begin
                    sq_rem_reg <= sq_shift;
                    sq_res_reg <= {sq_res_reg[30:0], 1'b0};
                end
            end
        end
    end

    always_comb
    begin
        out_word.quotient       = quotient_reg;
        out_word.remainder      = remainder_reg;
        out_word.divide_by_zero = out_zero_reg;
        out_word.divide_mode    = out_div_mode_reg;
        out_word.root           = root_reg;
        out_word.root_mode      = out_root_mode_reg;
    end

`ifndef NO_ASSERTIONS
    a_zero_flag: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> zero_flag_reg == (denominator_reg == 64'd0))
        else $error("zero flag mismatch");
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step && !status.last |=> count_reg == $past(count_reg) + 6'd1)
        else $error("step count slip");
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish && special_reg == SP_NONE |-> ur_reg[63:0] < ub_reg)
        else $error("remainder not reduced");
`endif
endmodule
